// ===== design/mpst_pkg.sv =====
// ---------------------------------------------------------------------------
// mpst_pkg
// shared types and constants for the masked pending slot tracker
// ---------------------------------------------------------------------------
`default_nettype none

package mpst_pkg;

   // number of tracked slots (2 .. 64)
   localparam int SLOT_COUNT = 38;
   // width of the slot field on the request and response words
   localparam int SLOT_W     = 6;
   // bits needed to index one slot of the bitmaps
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   // cursor runs 0 .. SLOT_COUNT, the top value meaning past the end
   localparam int CUR_W      = $clog2(SLOT_COUNT + 1);

   typedef logic [SLOT_COUNT-1:0] slot_bits_type;

   typedef enum logic [1:0] {
      CMD_MARK    = 2'd0,
      CMD_EXCLUDE = 2'd1,
      CMD_INCLUDE = 2'd2,
      CMD_POP     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] popped_slot;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the request word
      logic mask;     // restrict the pending map to the cursor window
      logic find;     // isolate the lowest set bit of the window
      logic commit;   // update state and load the response register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_pop;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/mpst_ctrl.sv =====
// ---------------------------------------------------------------------------
// mpst_ctrl
// sequencing state machine and response valid for the slot tracker
// ---------------------------------------------------------------------------
`default_nettype none

module mpst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mpst_pkg::dp_status_type dp_status,
   output mpst_pkg::dp_cmd_type    dp_cmd
);
   import mpst_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MASK = 4'b0010,
      ST_FIND = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = dp_status.req_is_pop ? ST_MASK : ST_DONE;
            end
         end
         ST_MASK: begin
            dp_cmd.mask = 1'b1;
            state_in    = ST_FIND;
         end
         ST_FIND: begin
            dp_cmd.find = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a commit never overwrites a word still waiting on the response side
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit over a pending response word");

   // every commit shows a response word in the next cycle
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |=> rsp_valid_ff)
      else $error("response valid missing after commit");

   // a pop always passes through the window and find steps
   a_pop_seq: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.load && dp_status.req_is_pop) |=> (state_ff == ST_MASK) ##1
      (state_ff == ST_FIND))
      else $error("pop skipped its search steps");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

endmodule

`default_nettype wire

// ===== design/mpst_dp.sv =====
// ---------------------------------------------------------------------------
// mpst_dp
// bitmaps, scan cursor, windowed lowest-bit search and response register
// ---------------------------------------------------------------------------
`default_nettype none

module mpst_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  mpst_pkg::req_type       req_payload,
   output mpst_pkg::rsp_type       rsp_payload,
   input  mpst_pkg::dp_cmd_type    dp_cmd,
   output mpst_pkg::dp_status_type dp_status
);
   import mpst_pkg::*;

   req_type       item_ff, item_in;
   slot_bits_type pending_ff, pending_in;
   slot_bits_type excl_ff, excl_in;
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   slot_bits_type masked_ff, masked_in;
   slot_bits_type onehot_ff, onehot_in;
   logic          hit_ff, hit_in;
   rsp_type       rsp_ff, rsp_in;

   logic             in_range;
   logic [IDX_W-1:0] slot_idx;
   slot_bits_type    slot_sel;
   logic [CUR_W-1:0] start;
   slot_bits_type    window;
   logic [IDX_W-1:0] hit_idx;

   assign dp_status.req_is_pop = (req_payload.cmd == CMD_POP);
   assign rsp_payload          = rsp_ff;

   assign item_in  = dp_cmd.load ? req_payload : item_ff;
   assign in_range = ({1'b0, item_ff.slot} < (SLOT_W + 1)'(SLOT_COUNT));
   assign slot_idx = item_ff.slot[IDX_W-1:0];
   assign slot_sel = slot_bits_type'(1) << slot_idx;

   // window of slots from the cursor up, cursor past the end restarts at 0
   assign start = (cursor_ff >= CUR_W'(SLOT_COUNT)) ? '0 : cursor_ff;
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         window[i] = (CUR_W'(i) >= start);
      end
   end
   assign masked_in = dp_cmd.mask ? (pending_ff & window) : masked_ff;

   // lowest set bit of the window
   assign onehot_in = dp_cmd.find ? (masked_ff & (~masked_ff + slot_bits_type'(1)))
                                  : onehot_ff;
   assign hit_in    = dp_cmd.find ? (|masked_ff) : hit_ff;

   // one-hot to index, an or over independent bits
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (onehot_ff[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   always_comb begin
      pending_in = pending_ff;
      excl_in    = excl_ff;
      cursor_in  = cursor_ff;
      rsp_in     = rsp_ff;
      if (dp_cmd.commit) begin
         rsp_in = '0;
         unique case (item_ff.cmd)
            CMD_MARK: begin
               if (in_range && !excl_ff[slot_idx]) begin
                  pending_in = pending_ff | slot_sel;
               end
            end
            CMD_EXCLUDE: begin
               if (in_range) begin
                  excl_in = excl_ff | slot_sel;
               end
            end
            CMD_INCLUDE: begin
               if (in_range) begin
                  excl_in = excl_ff & ~slot_sel;
               end
            end
            CMD_POP: begin
               pending_in = pending_ff & ~onehot_ff;
               cursor_in  = hit_ff ? (CUR_W'(hit_idx) + CUR_W'(1)) : CUR_W'(SLOT_COUNT);
               rsp_in.found       = hit_ff;
               rsp_in.popped_slot = SLOT_W'(hit_idx);
            end
            default: rsp_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         excl_ff    <= '0;
         cursor_ff  <= '0;
      end else begin
         pending_ff <= pending_in;
         excl_ff    <= excl_in;
         cursor_ff  <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      masked_ff <= masked_in;
      onehot_ff <= onehot_in;
      hit_ff    <= hit_in;
      rsp_ff    <= rsp_in;
   end

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CUR_W'(SLOT_COUNT))
      else $error("scan cursor beyond the end marker");

   // the search picks at most one slot, and exactly one when it hits
   a_onehot_hit: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.find |=> ($onehot0(onehot_ff) && (hit_ff == (onehot_ff != '0))))
      else $error("lowest-bit search not one-hot");

   // a popped slot is cleared from the pending map
   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit && item_ff.cmd == CMD_POP && hit_ff)
      |=> ((pending_ff & $past(onehot_ff)) == '0))
      else $error("popped slot still pending");

endmodule

`default_nettype wire

// ===== design/masked_pending_slot_tracker_top.sv =====
// ---------------------------------------------------------------------------
// masked_pending_slot_tracker_top
// pending/exclude bitmap pair with a round-robin pop from a scan cursor
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | req_payload  {cmd, slot}
//  rsp     | out       | rsp_valid / rsp_ready | rsp_payload  {found, popped_slot}
//
//  mark, exclude and include go from acceptance straight to the commit step
//  pop steps: window from the cursor, lowest-bit isolate, commit
//  the state machine handles one word at a time; a new word is taken while
//  the previous response still waits in the output register
//  a stalled response holds the commit step until the output register frees
//  synchronous reset clears both bitmaps, the cursor and the response valid
//
`default_nettype none

module masked_pending_slot_tracker_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mpst_pkg::rsp_type rsp_payload
);
   import mpst_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: idle, window, find, commit
   mpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // bitmaps, cursor, search registers and the response register
   mpst_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives command words into the masked pending slot tracker, predicts every
// response word from a private copy of the pending map, exclude map and scan
// cursor, and checks the responses in order, with random idling on both sides
// ---------------------------------------------------------------------------

module testbench;
   import mpst_pkg::*;

   // cycles with no handshake on either side before the run is abandoned
   localparam int QUIET_LIMIT = 2000;
   // cycles allowed for stray words after the last expected response
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_WORDS = 1400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   masked_pending_slot_tracker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // words still to be offered, and responses owed for words already taken
   req_type words_to_send[$];
   rsp_type responses_due[$];

   // private copy of the tracker state
   slot_bits_type pending_map = '0;
   slot_bits_type exclude_map = '0;
   int            scan_pos = 0;

   int words_taken = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // a window of the run with no idling on either side
   wire calm = (words_taken >= 400) && (words_taken < 650);

   // applies one command word to the private state and returns its response
   function automatic rsp_type track_word(req_type w);
      rsp_type r;
      int      s;
      r = '0;
      s = int'(w.slot);
      case (w.cmd)
         CMD_MARK: begin
            // an excluded slot never becomes pending
            if (s < SLOT_COUNT && !exclude_map[s])
               pending_map[s] = 1'b1;
         end
         CMD_EXCLUDE: begin
            if (s < SLOT_COUNT)
               exclude_map[s] = 1'b1;
         end
         CMD_INCLUDE: begin
            if (s < SLOT_COUNT)
               exclude_map[s] = 1'b0;
         end
         default: begin
            // cursor past the end restarts from slot 0; no wrap within one pop
            if (scan_pos >= SLOT_COUNT)
               scan_pos = 0;
            while (scan_pos < SLOT_COUNT && !r.found) begin
               if (pending_map[scan_pos]) begin
                  pending_map[scan_pos] = 1'b0;
                  r.found = 1'b1;
                  r.popped_slot = scan_pos[SLOT_W-1:0];
               end
               scan_pos++;
            end
         end
      endcase
      return r;
   endfunction

   task automatic queue_word(cmd_type c, int s);
      req_type w;
      w.cmd = c;
      w.slot = s[SLOT_W-1:0];
      words_to_send.push_back(w);
   endtask

   // slot mostly inside the map, now and then out of range
   function automatic int pick_slot();
      if ($urandom_range(0, 99) < 10)
         return $urandom_range(SLOT_COUNT, 63);
      return $urandom_range(0, SLOT_COUNT - 1);
   endfunction

   // driver: offers the next word when the channel is free; the prediction
   // is taken at the edge where the word is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            responses_due.push_back(track_word(req_payload));
            words_taken <= words_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (words_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
               req_valid <= 1'b1;
               req_payload <= words_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, and each response checked field by
   // field against the oldest prediction
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 16);
         if (rsp_valid && rsp_ready) begin
            if (responses_due.size() == 0) begin
               $display("%0t: response word with none due, actual found=%0b slot=%0d",
                        $time, rsp_payload.found, rsp_payload.popped_slot);
               error_count++;
            end else begin
               due = responses_due.pop_front();
               if (rsp_payload.found !== due.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, due.found, rsp_payload.found);
                  error_count++;
               end
               if (rsp_payload.popped_slot !== due.popped_slot) begin
                  $display("%0t: popped_slot expected %0d actual %0d",
                           $time, due.popped_slot, rsp_payload.popped_slot);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog: counts cycles in which no word moves on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int mode;
      int burst;
      int pushed;

      // directed opening
      queue_word(CMD_POP, 0);              // pop on an empty map
      queue_word(CMD_POP, 63);             // cursor past the end, still empty
      queue_word(CMD_MARK, 0);
      queue_word(CMD_MARK, SLOT_COUNT - 1);
      queue_word(CMD_MARK, SLOT_COUNT);    // out of range, ignored
      queue_word(CMD_MARK, 63);            // out of range, ignored
      queue_word(CMD_EXCLUDE, 5);
      queue_word(CMD_MARK, 5);             // excluded slot, mark ignored
      queue_word(CMD_EXCLUDE, 63);         // out of range, ignored
      queue_word(CMD_INCLUDE, 63);         // out of range, ignored
      queue_word(CMD_MARK, 20);
      queue_word(CMD_EXCLUDE, 20);         // pending bit stays
      queue_word(CMD_POP, 0);              // finds slot 0
      queue_word(CMD_MARK, 0);
      queue_word(CMD_POP, 42);             // slot 0 sits behind the cursor
      queue_word(CMD_POP, 63);             // last slot, cursor goes past the end
      queue_word(CMD_POP, 0);              // restart from 0
      queue_word(CMD_POP, 0);              // nothing left
      queue_word(CMD_INCLUDE, 5);
      queue_word(CMD_MARK, 5);
      queue_word(CMD_INCLUDE, 20);
      queue_word(CMD_EXCLUDE, 0);
      queue_word(CMD_EXCLUDE, SLOT_COUNT - 1);
      queue_word(CMD_INCLUDE, 0);
      queue_word(CMD_POP, 21);

      // random part in bursts of one flavour each
      pushed = 0;
      while (pushed < RANDOM_WORDS) begin
         mode = $urandom_range(0, 3);
         burst = $urandom_range(8, 40);
         repeat (burst) begin
            case (mode)
               // fill: mostly marks, a few pops
               0: queue_word(($urandom_range(0, 99) < 80) ? CMD_MARK : CMD_POP, pick_slot());
               // drain: mostly pops, runs past the end and restarts
               1: queue_word(($urandom_range(0, 99) < 80) ? CMD_POP : CMD_MARK, pick_slot());
               // exclude churn mixed with marks
               2: queue_word(cmd_type'($urandom_range(0, 2)), pick_slot());
               // anything, slot over its whole range
               default: queue_word(cmd_type'($urandom_range(0, 3)), $urandom_range(0, 63));
            endcase
         end
         pushed += burst;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (words_to_send.size() != 0 || req_valid || responses_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
design/mpst_pkg.sv
design/mpst_ctrl.sv
design/mpst_dp.sv
design/masked_pending_slot_tracker_top.sv
sim/testbench.sv
